// File: src/bsa_pkg.sv
// shared codes, state encoding and control/status bundles of the slot allocator
package bsa_pkg;

	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 10;
	localparam int TDATA_W = 16;

	// request commands
	localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

	// response status codes
	localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
	localparam logic [STAT_W-1:0] ST_CLEARED   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_SEL,
		S_A_RD,
		S_A_BIT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_F_SEG,
		S_F_ELT,
		S_F_WORD,
		S_F_RD,
		S_F_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_req;
		logic a_sel;
		logic a_bit;
		logic scan_rd;
		logic scan_chk;
		logic f_seg;
		logic f_elt;
		logic f_word;
		logic f_rd;
		logic f_wr;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic a_none;
		logic a_fail;
		logic bit_fail;
		logic need_scan;
		logic scan_end;
		logic scan_hit;
		logic seg_oob;
	} stat_t;

endpackage

// File: src/bsa_ram.sv
// generic simple dual-port ram with registered read
module bsa_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/bsa_datapath.sv
// allocator datapath: use bitmap ram, per-segment hints and pointers, address decode
module bsa_datapath #(
	parameter int SEGMENTS          = 4,
	parameter int WORDS_PER_SEGMENT = 8,
	parameter int WORD_BITS         = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsa_pkg::ctrl_t              ctrl,
	output bsa_pkg::stat_t              stat,
	input  logic [bsa_pkg::CMD_W-1:0]   req_cmd,
	input  logic [bsa_pkg::SLOT_W-1:0]  req_slot,
	output logic [bsa_pkg::STAT_W-1:0]  out_status,
	output logic [bsa_pkg::SLOT_W-1:0]  out_slot
);
	import bsa_pkg::*;

	localparam int SLOTS  = WORDS_PER_SEGMENT * WORD_BITS;
	localparam int TOTAL  = SEGMENTS * WORDS_PER_SEGMENT;
	localparam int SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int SEGC_W = $clog2(SEGMENTS + 1);
	localparam int WRD_W  = (WORDS_PER_SEGMENT > 1) ? $clog2(WORDS_PER_SEGMENT) : 1;
	localparam int HINT_W = $clog2(WORDS_PER_SEGMENT + 1);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int ELT_W  = $clog2(SLOTS);
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int POOL_W = $clog2(SEGMENTS * SLOTS + 1);

	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
	localparam logic [HINT_W-1:0]    WPS_H     = HINT_W'(WORDS_PER_SEGMENT);
	localparam logic [WRD_W-1:0]     LAST_WRD  = WRD_W'(WORDS_PER_SEGMENT - 1);
	localparam logic [BIT_W-1:0]     LAST_BIT  = BIT_W'(WORD_BITS - 1);
	localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(TOTAL - 1);
	localparam logic [SEGC_W-1:0]    SEG_END   = SEGC_W'(SEGMENTS);

	// per-segment state
	logic [SEGMENTS-1:0] space_q;
	logic [SEGMENTS-1:0] linear_q;
	logic [HINT_W-1:0]   hint_q     [SEGMENTS];
	logic [HINT_W-1:0]   lin_word_q [SEGMENTS];
	logic [BIT_W-1:0]    lin_bit_q  [SEGMENTS];
	logic [ADDR_W-1:0]   clr_addr_q;

	// working registers of the current request
	logic [SLOT_W-1:0]  idx_q;
	logic [SEGC_W-1:0]  seg_q;
	logic [POOL_W-1:0]  base_q;
	logic [ELT_W-1:0]   elt_q;
	logic [WRD_W-1:0]   word_q;
	logic [BIT_W-1:0]   bit_q;
	logic               lin_q;
	logic [HINT_W-1:0]  scan_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;

	logic [SEG_W-1:0]     sidx;
	logic [SEG_W-1:0]     pick_seg;
	logic                 pick_any;
	logic                 pick_lin;
	logic [HINT_W-1:0]    pick_word;
	logic                 pick_fail;
	logic [ADDR_W-1:0]    pick_row;
	logic [ADDR_W-1:0]    seg_row;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] zero_oh;
	logic [BIT_W-1:0]     zero_bit;
	logic [WORD_BITS-1:0] set_mask;
	logic [WORD_BITS-1:0] new_word;
	logic [BIT_W-1:0]     bit_sel;
	logic                 word_full;
	logic                 bit_fail;
	logic [POOL_W-1:0]    grant_full;
	logic [SEGC_W-1:0]    dec_seg;
	logic [WRD_W-1:0]     dec_word;
	logic [BIT_W-1:0]     dec_bit;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;

	assign sidx = seg_q[SEG_W-1:0];

	// lowest segment that still has space
	always_comb begin
		pick_seg = '0;
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (space_q[i]) begin
				pick_seg = SEG_W'(i);
			end
		end
	end

	assign pick_any  = |space_q;
	assign pick_lin  = linear_q[pick_seg];
	assign pick_word = pick_lin ? lin_word_q[pick_seg] : hint_q[pick_seg];
	assign pick_fail = pick_word >= WPS_H;
	assign pick_row  = ADDR_W'(pick_seg * WORDS_PER_SEGMENT);
	assign seg_row   = ADDR_W'(sidx * WORDS_PER_SEGMENT);

	// lowest clear bit of the word just read, as one-hot and as index
	always_comb begin
		zero_oh  = ~rd_data & (rd_data + WORD_BITS'(1));
		zero_bit = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (zero_oh[i]) begin
				zero_bit = zero_bit | BIT_W'(i);
			end
		end
	end

	assign set_mask   = lin_q ? (WORD_BITS'(1) << bit_q) : zero_oh;
	assign bit_sel    = lin_q ? bit_q : zero_bit;
	assign new_word   = rd_data | set_mask;
	assign word_full  = new_word == FULL_WORD;
	assign bit_fail   = !lin_q && (zero_oh == '0);
	assign grant_full = base_q + POOL_W'(word_q * WORD_BITS) + POOL_W'(bit_sel);

	// slot number split into segment and word by constant thresholds, bit by subtraction
	always_comb begin
		dec_seg = '0;
		for (int k = 1; k <= SEGMENTS; k++) begin
			if (int'(idx_q) >= k * SLOTS) begin
				dec_seg = SEGC_W'(k);
			end
		end
	end

	always_comb begin
		dec_word = '0;
		for (int k = 1; k < WORDS_PER_SEGMENT; k++) begin
			if (int'(elt_q) >= k * WORD_BITS) begin
				dec_word = WRD_W'(k);
			end
		end
	end

	assign dec_bit = BIT_W'(int'(elt_q) - int'(word_q) * WORD_BITS);

	always_comb begin
		stat           = '0;
		stat.clr_last  = clr_addr_q == LAST_ADDR;
		stat.a_none    = !pick_any;
		stat.a_fail    = pick_fail;
		stat.bit_fail  = bit_fail;
		stat.need_scan = !lin_q && word_full;
		stat.scan_end  = scan_q >= WPS_H;
		stat.scan_hit  = rd_data != FULL_WORD;
		stat.seg_oob   = dec_seg == SEG_END;
	end

	// ram ports
	always_comb begin
		if (ctrl.a_sel) begin
			ram_raddr = pick_row + ADDR_W'(pick_word[WRD_W-1:0]);
		end else if (ctrl.scan_rd) begin
			ram_raddr = seg_row + ADDR_W'(scan_q[WRD_W-1:0]);
		end else begin
			ram_raddr = seg_row + ADDR_W'(word_q);
		end
	end

	always_comb begin
		ram_we = ctrl.clr_step | (ctrl.a_bit & ~bit_fail) | ctrl.f_wr;
		if (ctrl.clr_step) begin
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (ctrl.a_bit) begin
			ram_waddr = seg_row + ADDR_W'(word_q);
			ram_wdata = new_word;
		end else begin
			ram_waddr = seg_row + ADDR_W'(word_q);
			ram_wdata = rd_data & ~(WORD_BITS'(1) << bit_q);
		end
	end

	bsa_ram #(
		.WIDTH  (WORD_BITS),
		.DEPTH  (TOTAL),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// segment state and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			space_q    <= '1;
			linear_q   <= '1;
			for (int i = 0; i < SEGMENTS; i++) begin
				hint_q[i]     <= '0;
				lin_word_q[i] <= '0;
				lin_bit_q[i]  <= '0;
			end
		end else begin
			if (ctrl.clr_step) begin
				clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
				space_q    <= '1;
				linear_q   <= '1;
				for (int i = 0; i < SEGMENTS; i++) begin
					hint_q[i]     <= '0;
					lin_word_q[i] <= '0;
					lin_bit_q[i]  <= '0;
				end
			end
			if (ctrl.a_bit && !bit_fail && lin_q) begin
				if (word_full) begin
					hint_q[sidx] <= hint_q[sidx] + HINT_W'(1);
				end
				if (bit_q == LAST_BIT) begin
					lin_bit_q[sidx]  <= '0;
					lin_word_q[sidx] <= lin_word_q[sidx] + HINT_W'(1);
				end else begin
					lin_bit_q[sidx] <= bit_q + BIT_W'(1);
				end
				if (word_q == LAST_WRD && bit_q == LAST_BIT) begin
					space_q[sidx] <= 1'b0;
				end
			end
			if (ctrl.scan_rd && stat.scan_end) begin
				space_q[sidx] <= 1'b0;
			end
			if (ctrl.scan_chk && stat.scan_hit) begin
				hint_q[sidx] <= scan_q;
			end
			if (ctrl.f_wr) begin
				linear_q[sidx] <= 1'b0;
				// a free below the hint, or into a full segment, pulls the hint down
				if (!space_q[sidx] || hint_q[sidx] > HINT_W'(word_q)) begin
					hint_q[sidx]  <= HINT_W'(word_q);
					space_q[sidx] <= 1'b1;
				end
			end
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (ctrl.load_req) begin
			idx_q      <= req_slot;
			res_slot_q <= '0;
			case (req_cmd)
				CMD_FREE:     res_status_q <= ST_FREED;
				CMD_FREE_ALL: res_status_q <= ST_CLEARED;
				default:      res_status_q <= ST_EXHAUSTED;
			endcase
		end
		if (ctrl.a_sel) begin
			seg_q  <= SEGC_W'(pick_seg);
			base_q <= POOL_W'(pick_seg * SLOTS);
			lin_q  <= pick_lin;
			word_q <= pick_word[WRD_W-1:0];
			bit_q  <= lin_bit_q[pick_seg];
		end
		if (ctrl.a_bit && !bit_fail) begin
			res_status_q <= ST_ALLOCATED;
			res_slot_q   <= SLOT_W'(grant_full);
			scan_q       <= HINT_W'(word_q) + HINT_W'(1);
		end
		if (ctrl.scan_chk && !stat.scan_hit) begin
			scan_q <= scan_q + HINT_W'(1);
		end
		if (ctrl.f_seg) begin
			seg_q  <= dec_seg;
			base_q <= POOL_W'(dec_seg * SLOTS);
		end
		if (ctrl.f_elt) begin
			elt_q <= ELT_W'(int'(idx_q) - int'(base_q));
		end
		if (ctrl.f_word) begin
			word_q <= dec_word;
		end
		if (ctrl.f_rd) begin
			bit_q <= dec_bit;
		end
		if (ctrl.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;

endmodule

// File: src/bsa_ctrl.sv
// allocator controller: sequences clear, allocate and free steps and the output register
module bsa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [bsa_pkg::CMD_W-1:0] req_cmd,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output bsa_pkg::ctrl_t            ctrl,
	input  bsa_pkg::stat_t            stat
);
	import bsa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   clr_resp_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = clr_resp_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					case (req_cmd)
						CMD_ALLOC:    state_d = S_A_SEL;
						CMD_FREE:     state_d = S_F_SEG;
						CMD_FREE_ALL: state_d = S_CLEAR;
						default:      state_d = S_RESP;
					endcase
				end
			end
			S_A_SEL: begin
				state_d = (stat.a_none || stat.a_fail) ? S_RESP : S_A_RD;
			end
			S_A_RD: state_d = S_A_BIT;
			S_A_BIT: begin
				if (!stat.bit_fail && stat.need_scan) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN_RD: state_d = stat.scan_end ? S_RESP : S_SCAN_CHK;
			S_SCAN_CHK: state_d = stat.scan_hit ? S_RESP : S_SCAN_RD;
			S_F_SEG: state_d = stat.seg_oob ? S_RESP : S_F_ELT;
			S_F_ELT: state_d = S_F_WORD;
			S_F_WORD: state_d = S_F_RD;
			S_F_RD: state_d = S_F_WR;
			S_F_WR: state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: ctrl.clr_step = 1'b1;
			S_IDLE: begin
				s_tready      = 1'b1;
				ctrl.load_req = s_tvalid;
			end
			S_A_SEL:    ctrl.a_sel = 1'b1;
			S_A_BIT:    ctrl.a_bit = 1'b1;
			S_SCAN_RD:  ctrl.scan_rd = 1'b1;
			S_SCAN_CHK: ctrl.scan_chk = 1'b1;
			S_F_SEG:    ctrl.f_seg = 1'b1;
			S_F_ELT:    ctrl.f_elt = 1'b1;
			S_F_WORD:   ctrl.f_word = 1'b1;
			S_F_RD:     ctrl.f_rd = 1'b1;
			S_F_WR:     ctrl.f_wr = 1'b1;
			S_RESP:     ctrl.out_load = out_free;
			default:    ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_resp_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && s_tvalid && req_cmd == CMD_FREE_ALL) begin
				clr_resp_q <= 1'b1;
			end else if (state_q == S_CLEAR && stat.clr_last) begin
				clr_resp_q <= 1'b0;
			end
			if (ctrl.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: src/bitmap_slot_allocator.sv
// bitmap slot allocator top level
//
// One request goes in on the s_ channel (cmd, slot_index) and exactly one
// response comes back on the m_ channel (status, granted_slot), in order.
// cmd allocate hands out the lowest free slot of the first segment with
// space, free releases slot_index, free all returns the pool to reset state.
// Requests are worked one at a time by the controller stepping through
// bitmap ram reads and writes; s_tready is high only between requests.
// Allocate picks a segment and its hint word, reads the word and sets a bit,
// then reads further bitmap words while the hint moves on; free decodes
// segment, word and bit, then reads and writes the word; free all clears one
// ram word per cycle; an unused command goes straight to the response. The next
// request is taken in the cycle after a result is loaded into the output register.
// After reset the same clearing pass runs with s_tready low.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and worked, and waits only to hand over its result.
module bitmap_slot_allocator #(
	parameter int SEGMENTS          = 4,
	parameter int WORDS_PER_SEGMENT = 8,
	parameter int WORD_BITS         = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [bsa_pkg::TDATA_W-1:0]  s_tdata,   // cmd [1:0], slot_index [11:2]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bsa_pkg::TDATA_W-1:0]  m_tdata    // status [1:0], granted_slot [11:2]
);
	import bsa_pkg::*;

	ctrl_t              ctrl;
	stat_t              stat;
	logic [CMD_W-1:0]   req_cmd;
	logic [SLOT_W-1:0]  req_slot;
	logic [STAT_W-1:0]  out_status;
	logic [SLOT_W-1:0]  out_slot;

	assign req_cmd  = s_tdata[CMD_W-1:0];
	assign req_slot = s_tdata[CMD_W+SLOT_W-1:CMD_W];

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_cmd  (req_cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	bsa_datapath #(
		.SEGMENTS          (SEGMENTS),
		.WORDS_PER_SEGMENT (WORDS_PER_SEGMENT),
		.WORD_BITS         (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.req_cmd    (req_cmd),
		.req_slot   (req_slot),
		.out_status (out_status),
		.out_slot   (out_slot)
	);

	assign m_tdata = {{(TDATA_W - STAT_W - SLOT_W){1'b0}}, out_slot, out_status};

endmodule

// File: src/bsa_checker.sv
// port-level checks of the slot allocator and their bind
module bsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bsa_pkg::TDATA_W-1:0] m_tdata
);
	import bsa_pkg::*;

	// stalled response holds
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response changed while stalled");

	// only a grant carries a slot number
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STAT_W-1:0] != ST_ALLOCATED
		|-> m_tdata[STAT_W+SLOT_W-1:STAT_W] == '0)
		else $error("slot number on a non-grant response");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:STAT_W+SLOT_W] == '0)
		else $error("padding bits set in response");

	// one request in flight: busy right after an acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/testbench.sv
// self-checking testbench of the bitmap slot allocator: directed, fill-up, random and backpressure requests
module testbench;
	import bsa_pkg::*;

	localparam int SEGS          = 4;
	localparam int WORDS_PER_SEG = 8;
	localparam int BITS_PER_WORD = 32;
	localparam int SLOTS_PER_SEG = WORDS_PER_SEG * BITS_PER_WORD;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 60;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [BITS_PER_WORD-1:0] WORD_FULL = '1;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} response_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;

	// allocator state as the testbench sees it
	logic [BITS_PER_WORD-1:0] use_words [SEGS*WORDS_PER_SEG];
	int                       hint_word [SEGS];
	bit                       has_space [SEGS];
	bit                       in_order  [SEGS];
	int                       order_pos [SEGS];

	response_t        expected_resp[$];
	logic [SLOT_W-1:0] live_slots[$];

	int  src_idle_pct  = 0;
	int  sink_stall_pct = 0;
	bit  hold_trigger  = 1'b0;
	bit  hold_seen     = 1'b0;
	int  hold_left     = 0;
	int  mismatch_count = 0;
	int  cycle_count   = 0;

	bitmap_slot_allocator #(
		.SEGMENTS(SEGS),
		.WORDS_PER_SEGMENT(WORDS_PER_SEG),
		.WORD_BITS(BITS_PER_WORD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void clear_pool();
		for (int i = 0; i < SEGS*WORDS_PER_SEG; i++)
			use_words[i] = '0;
		for (int s = 0; s < SEGS; s++) begin
			hint_word[s] = 0;
			has_space[s] = 1'b1;
			in_order[s]  = 1'b1;
			order_pos[s] = 0;
		end
	endfunction

	function automatic response_t allocate_slot();
		response_t r;
		int base, w, b, pos;
		bit found;
		r.status = ST_EXHAUSTED;
		r.slot   = '0;
		for (int s = 0; s < SEGS; s++) begin
			if (!has_space[s])
				continue;
			base = s * WORDS_PER_SEG;
			if (in_order[s]) begin
				pos = order_pos[s];
				if (pos >= SLOTS_PER_SEG)
					return r;
				w = pos / BITS_PER_WORD;
				b = pos % BITS_PER_WORD;
				use_words[base+w][b] = 1'b1;
				if (use_words[base+w] == WORD_FULL)
					hint_word[s]++;
				order_pos[s] = pos + 1;
				if (pos + 1 == SLOTS_PER_SEG)
					has_space[s] = 1'b0;
				r.status = ST_ALLOCATED;
				r.slot   = SLOT_W'(s * SLOTS_PER_SEG + pos);
				return r;
			end
			w = hint_word[s];
			if (w >= WORDS_PER_SEG)
				return r;
			b = BITS_PER_WORD;
			for (int i = 0; i < BITS_PER_WORD; i++) begin
				if (!use_words[base+w][i]) begin
					b = i;
					break;
				end
			end
			// hint word without a clear bit fails without trying other segments
			if (b >= BITS_PER_WORD)
				return r;
			use_words[base+w][b] = 1'b1;
			if (use_words[base+w] == WORD_FULL) begin
				found = 1'b0;
				for (int k = w + 1; k < WORDS_PER_SEG; k++) begin
					if (use_words[base+k] != WORD_FULL) begin
						hint_word[s] = k;
						found = 1'b1;
						break;
					end
				end
				if (!found)
					has_space[s] = 1'b0;
			end
			r.status = ST_ALLOCATED;
			r.slot   = SLOT_W'(s * SLOTS_PER_SEG + w * BITS_PER_WORD + b);
			return r;
		end
		return r;
	endfunction

	function automatic response_t compute_response(input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] idx);
		response_t r;
		int s, elt, w, b;
		r.status = ST_EXHAUSTED;
		r.slot   = '0;
		case (cmd)
			CMD_ALLOC: begin
				r = allocate_slot();
			end
			CMD_FREE: begin
				s   = int'(idx) / SLOTS_PER_SEG;
				elt = int'(idx) % SLOTS_PER_SEG;
				w   = elt / BITS_PER_WORD;
				b   = elt % BITS_PER_WORD;
				if (s < SEGS) begin
					use_words[s*WORDS_PER_SEG+w][b] = 1'b0;
					in_order[s] = 1'b0;
					if (!has_space[s] || hint_word[s] > w) begin
						hint_word[s] = w;
						has_space[s] = 1'b1;
					end
				end
				r.status = ST_FREED;
			end
			CMD_FREE_ALL: begin
				clear_pool();
				r.status = ST_CLEARED;
			end
			default: begin
				r.status = ST_EXHAUSTED;
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx);
		response_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-CMD_W-SLOT_W){1'b0}}, idx, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = compute_response(cmd, idx);
		expected_resp.push_back(r);
		if (r.status == ST_ALLOCATED && cmd == CMD_ALLOC)
			live_slots.push_back(r.slot);
		if (cmd == CMD_FREE_ALL)
			live_slots.delete();
	endtask

	// long receiver hold, counted down once per cycle after each trigger
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// response side: random stall, long hold on request, compare with oldest prediction
	always @(posedge clk) begin
		response_t got, want;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL bitmap_slot_allocator");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.slot   = m_tdata[SLOT_W+1:2];
			if (expected_resp.size() == 0) begin
				$display("%0t: unexpected response status %0d slot %0d", $time,
					got.status, got.slot);
				mismatch_count++;
			end else begin
				want = expected_resp.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, got.status);
					mismatch_count++;
				end
				if (got.slot !== want.slot) begin
					$display("%0t: granted_slot expected %0d actual %0d", $time,
						want.slot, got.slot);
					mismatch_count++;
				end
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic test_directed();
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_ALLOC, 10'h3FF);
		send_request(CMD_FREE, 10'd0);
		// linear mode has ended, the bitmap search finds slot 0 again
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_ALLOC, 10'h2AA);
		send_request(CMD_FREE, 10'd1);
		// freeing an already free slot
		send_request(CMD_FREE, 10'd1);
		send_request(CMD_ALLOC, 10'h155);
		send_request(CMD_FREE, 10'h3FF);
		send_request(CMD_FREE, 10'd256);
		send_request(CMD_FREE, 10'h2AA);
		send_request(CMD_UNUSED, 10'h3FF);
		send_request(CMD_UNUSED, 10'd0);
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_FREE_ALL, 10'h3FF);
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_FREE_ALL, 10'd0);
	endtask

	// fill the first segment, spill into the next, then hand slots back one by one
	task automatic test_exhaust();
		send_request(CMD_FREE_ALL, 10'd0);
		repeat (SLOTS_PER_SEG)
			send_request(CMD_ALLOC, SLOT_W'($urandom));
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_ALLOC, 10'h3FF);
		send_request(CMD_FREE, 10'd700);
		send_request(CMD_FREE, 10'd5);
		send_request(CMD_FREE, 10'd1000);
		repeat (4)
			send_request(CMD_ALLOC, 10'd0);
		for (int i = 288; i < 320; i++)
			send_request(CMD_FREE, SLOT_W'(i));
		repeat (34)
			send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_FREE, 10'd300);
		send_request(CMD_FREE, 10'd290);
		repeat (3)
			send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_FREE_ALL, 10'd0);
	endtask

	task automatic test_random(input int count);
		int pick, k;
		logic [SLOT_W-1:0] idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			idx  = SLOT_W'($urandom);
			if (pick < 52) begin
				send_request(CMD_ALLOC, idx);
			end else if (pick < 80 && live_slots.size() != 0) begin
				k = $urandom_range(live_slots.size() - 1);
				idx = live_slots[k];
				live_slots.delete(k);
				send_request(CMD_FREE, idx);
			end else if (pick < 94) begin
				send_request(CMD_FREE, idx);
			end else if (pick < 97) begin
				send_request(CMD_UNUSED, idx);
			end else begin
				send_request(CMD_FREE_ALL, idx);
			end
		end
	endtask

	// receiver holds off while requests keep coming, the block must stall its input
	task automatic test_backpressure();
		hold_trigger = ~hold_trigger;
		@(posedge clk);
		repeat (8)
			send_request(CMD_ALLOC, SLOT_W'($urandom));
		send_request(CMD_FREE, live_slots.size() != 0 ? live_slots[0] : 10'd0);
		send_request(CMD_ALLOC, 10'd0);
		send_request(CMD_FREE_ALL, 10'd0);
		send_request(CMD_ALLOC, 10'd0);
	endtask

	initial begin
		clear_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_exhaust();

		src_idle_pct = 0;  sink_stall_pct = 0;
		test_random(45);
		src_idle_pct = 81; sink_stall_pct = 0;
		test_random(45);
		src_idle_pct = 0;  sink_stall_pct = 81;
		test_random(45);
		src_idle_pct = 23; sink_stall_pct = 23;
		test_random(45);

		src_idle_pct = 0;  sink_stall_pct = 0;
		test_backpressure();

		s_tvalid <= 1'b0;
		while (expected_resp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS bitmap_slot_allocator");
		else
			$display("FAIL bitmap_slot_allocator");
		$finish;
	end

endmodule
